>>> hdl/mm64_pkg.sv
// Shared constants, sequencer states and multiplier status for the MurmurHash64A block.
package mm64_pkg;

	localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT = 47;

	// Sequencer states of the hash engine.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_DISPATCH,
		ST_K1,
		ST_K2,
		ST_HM,
		ST_FIN,
		ST_OUT
	} state_t;

	// Status from the iterative multiplier to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

>>> hdl/murmur64a_stream_hash.sv
// Top level of the streaming MurmurHash64A engine: sequencer, hash state and ports.
//
// A message enters on the input channel as little-endian 64-bit words, one word
// per item. The item that has first_item set also carries message_length, which
// loads the running hash with seed XOR (length times the mixing constant). Each
// item with eight or more valid bytes is mixed and folded into the hash; an item
// with one to seven bytes is XORed in as a tail; zero bytes leave the hash alone.
// An item with last_item set runs the final avalanche and produces one hash_value
// item on the output channel. The seed is written through seed_we/seed_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
//
// All arithmetic goes through one shared 32x32 multiplier that forms a 64-bit
// product modulo 2^64 in four steps. A full word needs three multiplies before
// the next item can be accepted, a tail word one and an empty word none. The
// first item of a message adds one multiply for the seed and the last item one
// more for the final avalanche; the last item's result then passes through
// ST_OUT into the output register that drives out_valid.
// in_stall is high while an item is being worked on. The result waits in an output
// register; a stalled receiver blocks the engine only when the next hash is done.
// Reset clears the seed, the running hash and all handshake state.
module murmur64a_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [63:0] seed_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [31:0] message_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	mm64_pkg::state_t    state_q;
	mm64_pkg::state_t    state_nxt;
	mm64_pkg::mul_stat_t mul_stat;

	logic [63:0] seed_q;
	logic [63:0] h_q;
	logic [63:0] word_q;
	logic [3:0]  count_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] hash_q;

	logic        mul_start;
	logic [63:0] mul_operand;
	logic [63:0] mul_product;
	logic [63:0] tail_word;
	logic        accept;
	logic        out_free;
	logic        full_word;

	function automatic logic [63:0] xor_shift(input logic [63:0] x);
		xor_shift = x ^ (x >> mm64_pkg::MIX_SHIFT);
	endfunction

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign full_word = count_q >= 4'd8;
	assign in_stall  = state_q != mm64_pkg::ST_IDLE;

	// Keep only the valid low bytes of a partial word.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail_word[8*i +: 8] = (4'(i) < count_q) ? word_q[8*i +: 8] : 8'h00;
		end
	end

	mm64_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (mul_operand),
		.product (mul_product),
		.stat    (mul_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm64_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and multiplier requests. Every multiply is launched on the
	// transition into the state that waits for its result.
	always_comb begin
		state_nxt   = state_q;
		mul_start   = 1'b0;
		mul_operand = word_q;
		unique case (state_q)
			mm64_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (first_item) begin
						mul_start   = 1'b1;
						mul_operand = {32'd0, message_length};
						state_nxt   = mm64_pkg::ST_SEED;
					end else begin
						state_nxt = mm64_pkg::ST_DISPATCH;
					end
				end
			end
			mm64_pkg::ST_SEED: begin
				if (mul_stat.done) begin
					state_nxt = mm64_pkg::ST_DISPATCH;
				end
			end
			mm64_pkg::ST_DISPATCH: begin
				priority if (full_word) begin
					mul_start   = 1'b1;
					mul_operand = word_q;
					state_nxt   = mm64_pkg::ST_K1;
				end else if (count_q != 4'd0) begin
					mul_start   = 1'b1;
					mul_operand = h_q ^ tail_word;
					state_nxt   = mm64_pkg::ST_HM;
				end else if (last_q) begin
					mul_start   = 1'b1;
					mul_operand = xor_shift(h_q);
					state_nxt   = mm64_pkg::ST_FIN;
				end else begin
					state_nxt = mm64_pkg::ST_IDLE;
				end
			end
			mm64_pkg::ST_K1: begin
				if (mul_stat.done) begin
					mul_start   = 1'b1;
					mul_operand = xor_shift(mul_product);
					state_nxt   = mm64_pkg::ST_K2;
				end
			end
			mm64_pkg::ST_K2: begin
				if (mul_stat.done) begin
					mul_start   = 1'b1;
					mul_operand = h_q ^ mul_product;
					state_nxt   = mm64_pkg::ST_HM;
				end
			end
			mm64_pkg::ST_HM: begin
				if (mul_stat.done) begin
					if (last_q) begin
						mul_start   = 1'b1;
						mul_operand = xor_shift(mul_product);
						state_nxt   = mm64_pkg::ST_FIN;
					end else begin
						state_nxt = mm64_pkg::ST_IDLE;
					end
				end
			end
			mm64_pkg::ST_FIN: begin
				if (mul_stat.done) begin
					state_nxt = mm64_pkg::ST_OUT;
				end
			end
			mm64_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = mm64_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mm64_pkg::ST_IDLE;
			end
		endcase
	end

	// Item fields are held for the whole computation.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q  <= data_word;
			count_q <= byte_count;
			last_q  <= last_item;
		end
		if (state_q == mm64_pkg::ST_OUT && out_free) begin
			hash_q <= xor_shift(mul_product);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 64'd0;
			h_q         <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (state_q == mm64_pkg::ST_SEED && mul_stat.done) begin
				h_q <= seed_q ^ mul_product;
			end else if (state_q == mm64_pkg::ST_HM && mul_stat.done) begin
				h_q <= mul_product;
			end
			if (state_q == mm64_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

`ifndef SYNTH
	// The multiplier is never restarted while it is still working.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiply launched while the multiplier is busy");

	// A finished product only arrives in a state that waits for one.
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == mm64_pkg::ST_SEED || state_q == mm64_pkg::ST_K1 ||
			state_q == mm64_pkg::ST_K2 || state_q == mm64_pkg::ST_HM ||
			state_q == mm64_pkg::ST_FIN))
		else $error("multiplier result arrived with nobody waiting");

	// A pending result is never overwritten while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mm64_pkg::ST_OUT && out_valid_q && out_stall) |=>
			(state_q == mm64_pkg::ST_OUT && $stable(hash_q)))
		else $error("pending hash overwritten under stall");

	// An accepted item always starts work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("accepted item did not start the engine");
`endif

endmodule

>>> hdl/mm64_mul.sv
// Iterative 64-bit multiply by the mixing constant, modulo 2^64, on one 32x32 multiplier.
module mm64_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         operand,
	output logic [63:0]         product,
	output mm64_pkg::mul_stat_t stat
);

	localparam logic [31:0] MUL_LO = mm64_pkg::MIX_MUL[31:0];
	localparam logic [31:0] MUL_HI = mm64_pkg::MIX_MUL[63:32];

	logic [63:0] a_q;
	logic [63:0] pp_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] pp_next;

	// Partial products: aL*mL, then aL*mH and aH*mL, whose low halves land in the upper word.
	always_comb begin
		unique case (step_q)
			2'd0: begin
				op_a = a_q[31:0];
				op_b = MUL_LO;
			end
			2'd1: begin
				op_a = a_q[31:0];
				op_b = MUL_HI;
			end
			default: begin
				op_a = a_q[63:32];
				op_b = MUL_LO;
			end
		endcase
	end

	assign pp_next = {32'd0, op_a} * {32'd0, op_b};

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= operand;
		end
		if (busy_q) begin
			pp_q <= pp_next;
			unique case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= pp_q;
				default: acc_q[63:32] <= acc_q[63:32] + pp_q[31:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the streaming MurmurHash64A block, with its own hash scoreboard.

// The scoreboard keeps its own copy of the seed and the running hash. Every
// accepted input item is folded in. Every last item queues the finished hash
// that the block has to produce.
class murmur_scoreboard;
	logic [63:0] seed_now = '0;
	logic [63:0] chain = '0;
	logic [63:0] pending_hashes[$];
	int unsigned mismatches = 0;
	int unsigned hashes_checked = 0;

	function void load_seed(logic [63:0] value);
		seed_now = value;
	endfunction

	function int unsigned outstanding();
		return pending_hashes.size();
	endfunction

	// Fold one accepted item into the running hash.
	function void take_item(logic [63:0] word, logic [3:0] count, logic first,
			logic last, logic [31:0] length);
		logic [63:0] h;
		logic [63:0] k;
		if (first) begin
			chain = seed_now ^ ({32'h0, length} * mm64_pkg::MIX_MUL);
		end
		h = chain;
		if (count >= 4'd8) begin
			k = word * mm64_pkg::MIX_MUL;
			k ^= k >> mm64_pkg::MIX_SHIFT;
			k = k * mm64_pkg::MIX_MUL;
			h = (h ^ k) * mm64_pkg::MIX_MUL;
		end else if (count != 4'd0) begin
			h = (h ^ (word & ((64'h1 << {count, 3'b000}) - 64'h1))) * mm64_pkg::MIX_MUL;
		end
		chain = h;
		if (last) begin
			h ^= h >> mm64_pkg::MIX_SHIFT;
			h = h * mm64_pkg::MIX_MUL;
			h ^= h >> mm64_pkg::MIX_SHIFT;
			pending_hashes.push_back(h);
		end
	endfunction

	// Compare one accepted hash with the oldest one expected.
	function void take_hash(logic [63:0] actual);
		logic [63:0] want;
		if (pending_hashes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: hash_value %h arrived with no message outstanding", actual);
			end
			return;
		end
		want = pending_hashes.pop_front();
		hashes_checked++;
		if (actual !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: hash_value expected %h, got %h", want, actual);
			end
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// The drain ends with this quiet wait, long enough for any item still in flight to finish.
	localparam int unsigned SETTLE_CYCLES = 40;
	// This is the length of the long output hold that fills the block up.
	localparam int unsigned HOLD_CYCLES = 400;
	// Each random phase runs for this many accepted input items.
	localparam int unsigned PHASE_ITEMS = 60;
	// The watchdog limit gives a correct run a wide margin.
	localparam int unsigned CYCLE_LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_we = 1'b0;
	logic [63:0] seed_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] data_word = '0;
	logic [3:0]  byte_count = '0;
	logic        first_item = 1'b0;
	logic        last_item = 1'b0;
	logic [31:0] message_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] hash_value;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_armed = 1'b0;
	int unsigned hold_count = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;

	murmur_scoreboard book = new;

	murmur64a_stream_hash uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.seed_we        (seed_we),
		.seed_wdata     (seed_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.first_item     (first_item),
		.last_item      (last_item),
		.message_length (message_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hash_value     (hash_value)
	);

	always #4 clk = ~clk;

	// The monitor samples both channels at the rising edge. All inputs change
	// through nonblocking assignments, so it sees the values from before the edge.
	// An input item and its own hash never meet at the same edge, so the order
	// of the two calls does not matter.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			book.take_item(data_word, byte_count, first_item, last_item, message_length);
		end
		if (arst_n && out_valid && !out_stall) begin
			book.take_hash(hash_value);
		end
	end

	// This process is the receiver. It stalls at random at the rate of the
	// current phase. Once the main sequence arms the hold, it keeps out_stall
	// high for a long stretch, counted here, so that the engine backs up and
	// stalls its input.
	always @(posedge clk) begin
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			hold_count = hold_count + 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// The watchdog ends a run that hangs, whether the hang is in a handshake or in the drain.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d hashes still expected",
				cycle_count, book.outstanding());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one item and hold it steady until the block takes it. Any idle
	// gap comes before valid rises and never while the item waits, so valid
	// never depends on stall.
	task automatic send_item(input logic [63:0] word, input logic [3:0] count,
			input logic first, input logic last, input logic [31:0] length);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		data_word      <= word;
		byte_count     <= count;
		first_item     <= first;
		last_item      <= last;
		message_length <= length;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// A well-formed message has full words and then a last item with 0 to 8
	// bytes. The length field usually matches the byte total. Sometimes it is
	// random, because the block only uses it to seed the hash. Items other than
	// the first carry a random length that the block must ignore.
	task automatic send_message(input int unsigned full_words, input logic [3:0] tail,
			input bit honest_length);
		logic [31:0] length;
		int unsigned i;
		length = honest_length ? 32'(full_words * 8 + tail) : $urandom();
		for (i = 0; i <= full_words; i++) begin
			send_item({$urandom(), $urandom()}, (i == full_words) ? tail : 4'd8,
				i == 0, i == full_words, (i == 0) ? length : $urandom());
		end
	endtask

	// Wait one edge so that the monitor has seen the last accepted item. Then
	// wait until no hash is outstanding, and then for the block to go quiet.
	task automatic drain();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (book.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The seed is only written while the block is idle, so the scoreboard can take it at once.
	task automatic write_seed(input logic [63:0] value);
		seed_we    <= 1'b1;
		seed_wdata <= value;
		@(posedge clk);
		seed_we <= 1'b0;
		book.load_seed(value);
	endtask

	// One random phase sets a new seed and then sends mostly short
	// well-formed messages. A few messages are long, and some single items
	// are noise with random flags and byte counts up to 15.
	task automatic random_phase(input logic [63:0] seed, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned start;
		write_seed(seed);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(99) < 12) begin
				send_item({$urandom(), $urandom()}, 4'($urandom_range(15)),
					1'($urandom()), 1'($urandom()), $urandom());
			end else if ($urandom_range(99) < 8) begin
				send_message($urandom_range(20, 8), 4'($urandom_range(8)),
					$urandom_range(99) < 90);
			end else begin
				send_message($urandom_range(3), 4'($urandom_range(8)),
					$urandom_range(99) < 90);
			end
		end
		drain();
	endtask

	initial begin
		int unsigned c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Items without first_item straight after reset must build on a running
		// hash of zero. A later item without first_item must build on the
		// unfinalized hash left by the previous last item.
		send_item({$urandom(), $urandom()}, 4'd8, 1'b0, 1'b0, 32'hFFFF_FFFF);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0, 1'b1, 32'h0);
		send_item({$urandom(), $urandom()}, 4'd8, 1'b0, 1'b1, $urandom());
		// An empty message is a single item with zero bytes.
		send_item({$urandom(), $urandom()}, 4'd0, 1'b1, 1'b1, 32'h0);
		drain();

		write_seed(64'hFFFF_FFFF_FFFF_FFFF);
		// These items test the extremes of the data word and the length.
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'd8);
		send_item(64'h0, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF);
		// Every tail size is sent with all ones in the word, so that bytes
		// beyond the count would show up if the block failed to mask them.
		for (c = 1; c <= 7; c++) begin
			send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'(c), 1'b1, 1'b1, c);
		end
		// A byte count above eight is a full word.
		send_item({$urandom(), $urandom()}, 4'd9, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item({$urandom(), $urandom()}, 4'd15, 1'b1, 1'b1, 32'd15);
		// This message has a partial word in the middle, then an empty word,
		// and a length on a later item that the block must ignore.
		send_item({$urandom(), $urandom()}, 4'd5, 1'b1, 1'b0, 32'd21);
		send_item({$urandom(), $urandom()}, 4'd0, 1'b0, 1'b0, $urandom());
		send_item({$urandom(), $urandom()}, 4'd8, 1'b0, 1'b0, $urandom());
		send_item({$urandom(), $urandom()}, 4'd8, 1'b0, 1'b1, 32'hFFFF_FFFF);
		drain();

		// Each idling pattern runs once in the first round.
		random_phase(64'h0, 0, 0);
		random_phase({$urandom(), $urandom()}, 56, 0);
		random_phase({$urandom(), $urandom()}, 0, 56);
		random_phase(64'hFFFF_FFFF_FFFF_FFFF, 18, 18);

		// Under back pressure the receiver holds off for a long stretch while
		// single-word messages keep coming. The output register fills, the
		// engine finishes the next hash and then stalls its input.
		write_seed({$urandom(), $urandom()});
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_armed     = 1'b1;
		repeat (12) send_item({$urandom(), $urandom()}, 4'd8, 1'b1, 1'b1, 32'd8);
		drain();

		// The second round uses fresh seeds.
		random_phase(64'h5555_5555_AAAA_AAAA, 0, 0);
		random_phase({$urandom(), $urandom()}, 56, 0);
		random_phase({$urandom(), $urandom()}, 0, 56);
		random_phase({$urandom(), $urandom()}, 18, 18);

		$display("Sent %0d input items across 10 seed writes; %0d hashes compared, %0d mismatches.",
			items_sent, book.hashes_checked, book.mismatches);
		$display("Covered tails of every size, empty and unseeded messages, random flags,");
		$display("idle and stall mixes, and a long output hold.");
		if (book.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
